>>> rtl/core/ukf_pkg.sv
// Package for the unique-key FIFO with lookup: sizes, operation codes,
// request/response payload structs and the controller command struct.
// No dependencies.
package ukf_pkg;

  localparam int DEPTH        = 16;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int IDX_BITS     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_BITS     = $clog2(DEPTH + 1);
  localparam int OP_BITS      = 3;

  localparam logic [OP_BITS-1:0] OP_ENQUEUE = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DEQUEUE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_PEEK    = 3'd2;
  localparam logic [OP_BITS-1:0] OP_LOOKUP  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_CLEAR   = 3'd4;

  typedef struct packed {
    logic [OP_BITS-1:0]      operation;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    payload_present;
  } req_t;

  typedef struct packed {
    logic                    ok;
    logic [KEY_BITS-1:0]     key_out;
    logic [PAYLOAD_BITS-1:0] payload_out;
    logic [OCC_BITS-1:0]     occupancy;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic match;
    logic exec;
  } ctl_cmd_t;

endpackage

>>> rtl/core/ukf_ctrl.sv
// Controller for the unique-key FIFO: one-hot sequencer that steps a
// request through capture, key match, execute and response. Uses ukf_pkg.
module ukf_ctrl
  import ukf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req_valid) state_next = ST_MATCH;
      ST_MATCH: state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_RESP;
      ST_RESP:  if (rsp_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_RESP);
  assign cmd.load  = req_valid && (state == ST_IDLE);
  assign cmd.match = (state == ST_MATCH);
  assign cmd.exec  = (state == ST_EXEC);

endmodule

>>> rtl/core/ukf_datapath.sv
// Datapath for the unique-key FIFO: request register, key cells with valid
// bits and parallel compare, payload memory, queue pointers and response
// registers. Uses ukf_pkg.
module ukf_datapath
  import ukf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  ctl_cmd_t cmd,
  input  req_t     req,
  output rsp_t     rsp
);

  req_t                    req_q;
  logic [KEY_BITS-1:0]     keys [DEPTH];
  logic [DEPTH-1:0]        valid;
  logic [IDX_BITS-1:0]     head;
  logic [IDX_BITS-1:0]     tail;
  logic [OCC_BITS-1:0]     count;
  logic [PAYLOAD_BITS-1:0] mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] rd_data;
  logic                    hit;
  logic [IDX_BITS-1:0]     hit_idx;
  logic                    rsp_ok;
  logic [KEY_BITS-1:0]     rsp_key;
  logic                    rsp_pl;

  logic [DEPTH-1:0]        match_vec;
  logic [IDX_BITS-1:0]     match_idx;
  logic                    not_empty;
  logic                    enq_ok;
  logic                    deq_ok;
  logic                    peek_ok;
  logic                    look_ok;
  logic                    clr;
  logic [IDX_BITS-1:0]     head_inc;
  logic [IDX_BITS-1:0]     tail_inc;
  logic [IDX_BITS-1:0]     rd_addr;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_vec[i] = valid[i] && (keys[i] == req_q.key);
    end
  end

  // held keys are unique, so at most one cell matches: OR-encode the index
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_vec[i]) match_idx = match_idx | IDX_BITS'(i);
    end
  end

  assign not_empty = (count != '0);
  assign enq_ok  = (req_q.operation == OP_ENQUEUE) && (req_q.key != '0) &&
                   req_q.payload_present && (count != OCC_BITS'(DEPTH)) && !hit;
  assign deq_ok  = (req_q.operation == OP_DEQUEUE) && not_empty;
  assign peek_ok = (req_q.operation == OP_PEEK) && not_empty;
  assign look_ok = (req_q.operation == OP_LOOKUP) && (req_q.key != '0) && hit;
  assign clr     = (req_q.operation == OP_CLEAR);

  assign head_inc = (head == IDX_BITS'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == IDX_BITS'(DEPTH - 1)) ? '0 : tail + 1'b1;
  assign rd_addr  = peek_ok ? head : hit_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) req_q <= req;
    if (cmd.match) begin
      hit     <= |match_vec;
      hit_idx <= match_idx;
    end
    if (cmd.exec) begin
      rsp_ok  <= enq_ok || deq_ok || peek_ok || look_ok || clr;
      rsp_pl  <= peek_ok || look_ok;
      rsp_key <= peek_ok ? keys[head] : (look_ok ? req_q.key : '0);
      if (enq_ok) keys[tail] <= req_q.key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && enq_ok) mem[tail] <= req_q.payload;
    if (cmd.exec) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      if (clr) begin
        valid <= '0;
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end else if (enq_ok) begin
        valid[tail] <= 1'b1;
        tail        <= tail_inc;
        count       <= count + 1'b1;
      end else if (deq_ok) begin
        valid[head] <= 1'b0;
        head        <= head_inc;
        count       <= count - 1'b1;
      end
    end
  end

  assign rsp.ok          = rsp_ok;
  assign rsp.key_out     = rsp_key;
  assign rsp.payload_out = rsp_pl ? rd_data : '0;
  assign rsp.occupancy   = count;

endmodule

>>> rtl/core/unique_key_fifo_with_lookup.sv
// Top level of the unique-key FIFO with lookup: joins controller and datapath.
// Uses ukf_pkg, ukf_ctrl, ukf_datapath.
//
// Each request (enqueue, dequeue, peek, lookup, clear) yields exactly one
// response carrying a success flag, the found or peeked entry and the
// occupancy after the operation. One request is handled at a time. The
// request is captured on acceptance, then a parallel key compare over all
// cells is registered, then the queue update and the payload memory read
// are done. The response is then offered and held until it is taken, and
// a new request is accepted only after the response has been taken. Keys
// sit in registers so every cell is compared at once; payloads sit in a
// memory with a registered read port.
module unique_key_fifo_with_lookup
  import ukf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  ctl_cmd_t cmd;

  ukf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  ukf_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule
